/* src/fifo_with_search_delete_unit_defines.svh */
// Assertion macros used by the queue RTL.
// Each macro expects clk and rst_n in scope.
`ifndef FIFO_WITH_SEARCH_DELETE_UNIT_DEFINES_SVH
`define FIFO_WITH_SEARCH_DELETE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fsd_pkg.sv */
`default_nettype none

package fsd_pkg;

    localparam int ACTION_W = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd3;

endpackage

`default_nettype wire

/* src/fifo_with_search_delete_unit.sv */
// Push and pop go from the input beat through S_HEAD_RD and S_HEAD_OUT to a valid result.
// Search and delete compare entries from the head, stopping at the first match;
// a delete then closes the gap by moving each entry behind the match up one slot.
// Throughput: one item at a time, next beat taken the cycle after the result loads;
// the slot RAM's one read port and the single comparator set the pace.
// Reset: entry count cleared, queue empty, no result pending; slot contents are not cleared.
`default_nettype none

module fifo_with_search_delete_unit #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16,
    localparam int PTR_W  = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input beat
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [fsd_pkg::ACTION_W-1:0] action,
    input  wire logic [ID_BITS-1:0]           item_id,
    // result beat
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              found,
    output logic                              rejected,
    output logic                              head_valid,
    output logic      [ID_BITS-1:0]           head_id,
    output logic                              is_empty,
    output logic      [CNT_W-1:0]             entry_count
);

    import fsd_pkg::*;

    `include "fifo_with_search_delete_unit_defines.svh"

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;   // issue slot read for compare
    localparam logic [2:0] S_SCAN_CMP = 3'd2;   // compare read data with the key
    localparam logic [2:0] S_SHIFT_RD = 3'd3;   // read the slot behind the gap
    localparam logic [2:0] S_SHIFT_WR = 3'd4;   // move it into the gap
    localparam logic [2:0] S_HEAD_RD  = 3'd5;   // read the head slot
    localparam logic [2:0] S_HEAD_OUT = 3'd6;   // load the result register

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_PTR : p - 1'b1;
    endfunction

    // Control state. The queue is a ring: head_reg is the oldest entry,
    // tail_reg the next free slot.
    logic [2:0]          state_reg,   state_next;
    logic [PTR_W-1:0]    head_reg,    head_next;
    logic [PTR_W-1:0]    tail_reg,    tail_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [PTR_W-1:0]    scan_reg,    scan_next;    // ring address being scanned / gap
    logic [PTR_W-1:0]    idx_reg,     idx_next;     // queue position of scan_reg
    logic [PTR_W-1:0]    rem_reg,     rem_next;     // entries still to move up
    logic                hit_reg,     hit_next;
    logic                rej_reg,     rej_next;
    logic                out_valid_reg, out_valid_next;

    // Payload holding registers (no reset needed)
    logic [ACTION_W-1:0] act_reg,     act_next;
    logic [ID_BITS-1:0]  key_reg,     key_next;
    logic                res_found_reg,  res_found_next;
    logic                res_rej_reg,    res_rej_next;
    logic [ID_BITS-1:0]  res_head_reg,   res_head_next;
    logic [CNT_W-1:0]    res_count_reg,  res_count_next;

    // Slot RAM port
    logic                mem_we;
    logic [PTR_W-1:0]    mem_waddr;
    logic [ID_BITS-1:0]  mem_wdata;
    logic [PTR_W-1:0]    mem_raddr;
    logic [ID_BITS-1:0]  mem_rdata;

    fsd_ram #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Input is taken only between operations; a pending result does not block it.
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        hit_next       = hit_reg;
        rej_next       = rej_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        res_found_next = res_found_reg;
        res_rej_next   = res_rej_reg;
        res_head_next  = res_head_reg;
        res_count_next = res_count_reg;
        out_valid_next = out_valid_reg;

        mem_we    = 1'b0;
        mem_waddr = tail_reg;
        mem_wdata = key_reg;
        mem_raddr = head_reg;   // keeps head data steady while a result waits

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    key_next   = item_id;
                    hit_next   = 1'b0;
                    rej_next   = 1'b0;
                    state_next = S_HEAD_RD;
                    case (action)
                        ACT_PUSH:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = tail_reg;
                                mem_wdata  = item_id;
                                tail_next  = ptr_inc(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                head_next  = ptr_inc(head_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            // search or delete: walk from the head
                            if (count_reg != '0)
                            begin
                                scan_next  = head_reg;
                                idx_next   = '0;
                                state_next = S_SCAN_RD;
                            end
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                mem_raddr  = scan_reg;
                state_next = S_SCAN_CMP;
            end

            S_SCAN_CMP:
            begin
                if (mem_rdata == key_reg)
                begin
                    hit_next = 1'b1;
                    if (act_reg == ACT_DELETE)
                    begin
                        rem_next   = PTR_W'(count_reg - CNT_W'(idx_reg) - 1'b1);
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = S_HEAD_RD;
                    end
                end
                else if ((CNT_W'(idx_reg) + 1'b1) == count_reg)
                begin
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    scan_next  = ptr_inc(scan_reg);
                    state_next = S_SCAN_RD;
                end
            end

            S_SHIFT_RD:
            begin
                if (rem_reg == '0)
                begin
                    // gap has reached the tail
                    tail_next  = ptr_dec(tail_reg);
                    count_next = count_reg - 1'b1;
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    mem_raddr  = ptr_inc(scan_reg);
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = scan_reg;
                mem_wdata  = mem_rdata;
                scan_next  = ptr_inc(scan_reg);
                rem_next   = rem_reg - 1'b1;
                state_next = S_SHIFT_RD;
            end

            S_HEAD_RD:
            begin
                mem_raddr  = head_reg;
                state_next = S_HEAD_OUT;
            end

            S_HEAD_OUT:
            begin
                mem_raddr = head_reg;
                if (!out_valid_reg || out_ready)
                begin
                    res_found_next = hit_reg;
                    res_rej_next   = rej_reg;
                    res_head_next  = (count_reg != '0) ? mem_rdata : '0;
                    res_count_next = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            idx_reg       <= '0;
            rem_reg       <= '0;
            hit_reg       <= 1'b0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            idx_reg       <= idx_next;
            rem_reg       <= rem_next;
            hit_reg       <= hit_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        res_found_reg <= res_found_next;
        res_rej_reg   <= res_rej_next;
        res_head_reg  <= res_head_next;
        res_count_reg <= res_count_next;
    end

    // Result beat
    assign out_valid   = out_valid_reg;
    assign found       = res_found_reg;
    assign rejected    = res_rej_reg;
    assign head_id     = res_head_reg;
    assign entry_count = res_count_reg;
    assign head_valid  = (res_count_reg != '0);
    assign is_empty    = (res_count_reg == '0);

    // Every operation leaves S_IDLE when it is taken, so an input beat is
    // never followed directly by another.
    `FSD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted back to back")

    // A refused push is only reported with a full queue.
    `FSD_ASSERT_IMP(a_reject_full, out_valid && rejected, entry_count == FULL_CNT, "reject when not full")

    // A push never reports a match, so the two flags never stand together.
    `FSD_ASSERT_IMP(a_flags_exclusive, out_valid, !(found && rejected), "found and rejected both set")

endmodule

`default_nettype wire

/* src/fsd_ram.sv */
`default_nettype none

// Slot storage: one write port, one registered read port, no reset.
module fsd_ram #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16,
    localparam int PTR_W  = $clog2(DEPTH)
) (
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [PTR_W-1:0]   waddr,
    input  wire logic [ID_BITS-1:0] wdata,
    input  wire logic [PTR_W-1:0]   raddr,
    output logic      [ID_BITS-1:0] rdata
);

    logic [ID_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
